// File: rtl/pcwe_pkg.sv
// Shared types, constants and the LED byte encoder for the PWM watchdog encoder.
`timescale 1ns / 1ps
`default_nettype none
package pcwe_pkg;

   localparam int CHANNELS      = 16;
   localparam int CHECK_DIVIDER = 10;
   localparam int TIME_W        = 32;

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PH_W  = (CHECK_DIVIDER > 1) ? $clog2(CHECK_DIVIDER) : 1;
   localparam int CMP_W = (TIME_W > 33) ? TIME_W : 33;
   localparam int PC_W  = 4;

   localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;
   localparam logic [15:0] DUTY_MAX_RESET = 16'hFFFF;
   localparam logic [11:0] DUTY_FULL      = 12'h0FFF;
   localparam logic [4:0]  FULL_FLAG      = 5'h10;

   typedef enum logic [2:0] {
      CSR_TABLE_CHANNEL = 3'd0,
      CSR_TIMEOUT       = 3'd1,
      CSR_FALLBACK      = 3'd2,
      CSR_DUTY_MIN      = 3'd3,
      CSR_DUTY_MAX      = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      UOP_NOP        = 4'd0,
      UOP_FETCH      = 4'd1,
      UOP_CMD_READ   = 4'd2,
      UOP_CMD_UPDATE = 4'd3,
      UOP_PUSH_CMD   = 4'd4,
      UOP_TICK_START = 4'd5,
      UOP_SCAN_READ  = 4'd6,
      UOP_PUSH_PEND  = 4'd7,
      UOP_SET_PEND   = 4'd8,
      UOP_NEXT_CH    = 4'd9,
      UOP_PUSH_LAST  = 4'd10
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER     = 4'd0,
      COND_ALWAYS    = 4'd1,
      COND_NO_ITEM   = 4'd2,
      COND_IS_TICK   = 4'd3,
      COND_SKIP      = 4'd4,
      COND_PHASE_NZ  = 4'd5,
      COND_NO_HIT    = 4'd6,
      COND_MORE_CH   = 4'd7,
      COND_OUT_BUSY  = 4'd8,
      COND_WAIT_PEND = 4'd9
   } cond_type;

   typedef struct packed {
      uop_type          uop;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic no_item;
      logic is_tick;
      logic skip;
      logic phase_nz;
      logic no_hit;
      logic more_ch;
      logic out_busy;
      logic wait_pend;
   } status_type;

   typedef struct packed {
      logic        op;
      logic [3:0]  channel;
      logic signed [31:0] command_value;
      logic [31:0] time_ms;
   } req_word_type;

   typedef struct packed {
      logic [3:0] out_channel;
      logic [7:0] on_low;
      logic [4:0] on_high;
      logic [7:0] off_low;
      logic [4:0] off_high;
      logic       from_timeout;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0] on_high;
      logic [7:0] off_low;
      logic [4:0] off_high;
   } led_bytes_type;

   // Full on, full off, or off count = duty/16 + 1.
   function automatic led_bytes_type led_encode(input logic [15:0] duty);
      logic [11:0]   d;
      logic [12:0]   p;
      led_bytes_type r;
      d = duty[15:4];
      p = {1'b0, d} + 13'd1;
      r = '0;
      if (d == DUTY_FULL) begin
         r.on_high = FULL_FLAG;
      end else if (d == 12'd0) begin
         r.off_high = FULL_FLAG;
      end else begin
         r.off_low  = p[7:0];
         r.off_high = {1'b0, p[11:8]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/pcwe_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
module pcwe_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pcwe_pkg::status_type    status,
   output pcwe_pkg::ctrl_word_type      ctl
);

   localparam logic [pcwe_pkg::PC_W-1:0] PC_FETCH   = 4'd0;
   localparam logic [pcwe_pkg::PC_W-1:0] PC_PUSH    = 4'd4;
   localparam logic [pcwe_pkg::PC_W-1:0] PC_TICK    = 4'd6;
   localparam logic [pcwe_pkg::PC_W-1:0] PC_SCAN    = 4'd7;
   localparam logic [pcwe_pkg::PC_W-1:0] PC_EMIT    = 4'd9;
   localparam logic [pcwe_pkg::PC_W-1:0] PC_NEXT    = 4'd11;
   localparam logic [pcwe_pkg::PC_W-1:0] PC_FLUSH   = 4'd12;

   logic [pcwe_pkg::PC_W-1:0] pc_ff;
   logic [pcwe_pkg::PC_W-1:0] pc_in;
   logic                      take;

   function automatic pcwe_pkg::ctrl_word_type rom(input logic [pcwe_pkg::PC_W-1:0] pc);
      pcwe_pkg::ctrl_word_type w;
      w.target = PC_FETCH;
      case (pc)
         4'd0: begin
            w.uop = pcwe_pkg::UOP_FETCH;      w.cond = pcwe_pkg::COND_NO_ITEM;
         end
         4'd1: begin
            w.uop = pcwe_pkg::UOP_NOP;        w.cond = pcwe_pkg::COND_IS_TICK;
            w.target = PC_TICK;
         end
         4'd2: begin
            w.uop = pcwe_pkg::UOP_CMD_READ;   w.cond = pcwe_pkg::COND_NEVER;
         end
         4'd3: begin
            w.uop = pcwe_pkg::UOP_CMD_UPDATE; w.cond = pcwe_pkg::COND_SKIP;
         end
         4'd4: begin
            w.uop = pcwe_pkg::UOP_PUSH_CMD;   w.cond = pcwe_pkg::COND_OUT_BUSY;
            w.target = PC_PUSH;
         end
         4'd5: begin
            w.uop = pcwe_pkg::UOP_NOP;        w.cond = pcwe_pkg::COND_ALWAYS;
         end
         4'd6: begin
            w.uop = pcwe_pkg::UOP_TICK_START; w.cond = pcwe_pkg::COND_PHASE_NZ;
         end
         4'd7: begin
            w.uop = pcwe_pkg::UOP_SCAN_READ;  w.cond = pcwe_pkg::COND_NEVER;
         end
         4'd8: begin
            w.uop = pcwe_pkg::UOP_NOP;        w.cond = pcwe_pkg::COND_NO_HIT;
            w.target = PC_NEXT;
         end
         4'd9: begin
            w.uop = pcwe_pkg::UOP_PUSH_PEND;  w.cond = pcwe_pkg::COND_WAIT_PEND;
            w.target = PC_EMIT;
         end
         4'd10: begin
            w.uop = pcwe_pkg::UOP_SET_PEND;   w.cond = pcwe_pkg::COND_NEVER;
         end
         4'd11: begin
            w.uop = pcwe_pkg::UOP_NEXT_CH;    w.cond = pcwe_pkg::COND_MORE_CH;
            w.target = PC_SCAN;
         end
         4'd12: begin
            w.uop = pcwe_pkg::UOP_PUSH_LAST;  w.cond = pcwe_pkg::COND_WAIT_PEND;
            w.target = PC_FLUSH;
         end
         default: begin
            w.uop = pcwe_pkg::UOP_NOP;        w.cond = pcwe_pkg::COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

   assign ctl = rom(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         pcwe_pkg::COND_NEVER:     take = 1'b0;
         pcwe_pkg::COND_ALWAYS:    take = 1'b1;
         pcwe_pkg::COND_NO_ITEM:   take = status.no_item;
         pcwe_pkg::COND_IS_TICK:   take = status.is_tick;
         pcwe_pkg::COND_SKIP:      take = status.skip;
         pcwe_pkg::COND_PHASE_NZ:  take = status.phase_nz;
         pcwe_pkg::COND_NO_HIT:    take = status.no_hit;
         pcwe_pkg::COND_MORE_CH:   take = status.more_ch;
         pcwe_pkg::COND_OUT_BUSY:  take = status.out_busy;
         pcwe_pkg::COND_WAIT_PEND: take = status.wait_pend;
         default:                  take = 1'b1;
      endcase
      pc_in = take ? ctl.target : pc_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pcwe_dp.sv
// Datapath: channel tables, watchdog times, clamp, scan unit and output register.
`timescale 1ns / 1ps
`default_nettype none
module pcwe_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pcwe_pkg::ctrl_word_type    ctl,
   output pcwe_pkg::status_type            status,
   input  wire logic                       req_valid,
   input  wire pcwe_pkg::req_word_type     req_word,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [31:0]                csr_wdata,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valid,
   output pcwe_pkg::rsp_word_type          rsp_word
);

   localparam int CW = pcwe_pkg::CH_W;
   localparam int TW = pcwe_pkg::TIME_W;
   localparam int NCH = pcwe_pkg::CHANNELS;

   // configuration tables
   logic [3:0]  table_ch_ff;
   logic [31:0] timeout_table_ff  [NCH];
   logic [15:0] fallback_table_ff [NCH];
   logic [15:0] min_table_ff      [NCH];
   logic [15:0] max_table_ff      [NCH];

   // per-channel command history
   logic [TW-1:0] last_set_ff    [NCH];
   logic [TW-1:0] last_change_ff [NCH];
   logic [30:0]   last_cmd_ff    [NCH];

   pcwe_pkg::req_word_type item_ff;
   logic          cmd_bad_ff;
   logic          cmd_changed_ff;
   logic [31:0]   ent_tmo_ff;
   logic [15:0]   ent_min_ff;
   logic [15:0]   ent_max_ff;
   logic [15:0]   duty_ff;

   logic [pcwe_pkg::PH_W-1:0] phase_ff;
   logic [pcwe_pkg::PH_W-1:0] phase_in;
   logic [CW-1:0] scan_ch_ff;
   logic          to_nz_ff;
   logic [32:0]   mag_ff;
   logic [TW-1:0] diff_ff;
   logic [15:0]   fb_ff;

   logic          pend_ff;
   logic [CW-1:0] pend_ch_ff;
   logic [15:0]   pend_duty_ff;

   logic                   rsp_valid_ff;
   pcwe_pkg::rsp_word_type rsp_word_ff;
   pcwe_pkg::rsp_word_type rsp_word_in;
   pcwe_pkg::led_bytes_type led;

   logic [CW-1:0] cmd_idx;
   logic [CW-1:0] tab_idx;
   logic          tab_ok;
   logic [31:0]   cmd_val;
   logic [TW-1:0] item_time;
   logic [31:0]   scan_tmo;
   logic [15:0]   clamp;
   logic          skip;
   logic          hit;
   logic          out_busy;
   logic          push_cmd;
   logic          push_pend;
   logic          push;

   assign cmd_idx   = CW'(item_ff.channel);
   assign tab_idx   = CW'(table_ch_ff);
   assign tab_ok    = int'(table_ch_ff) < NCH;
   assign cmd_val   = item_ff.command_value;
   assign item_time = TW'(item_ff.time_ms);
   assign scan_tmo  = timeout_table_ff[scan_ch_ff];

   always_comb begin
      if (cmd_val > {16'd0, ent_max_ff}) begin
         clamp = ent_max_ff;
      end else if (cmd_val < {16'd0, ent_min_ff}) begin
         clamp = ent_min_ff;
      end else begin
         clamp = cmd_val[15:0];
      end
   end

   assign skip      = cmd_bad_ff | (!cmd_changed_ff & (ent_tmo_ff != 32'd0));
   assign hit       = to_nz_ff && (pcwe_pkg::CMP_W'(diff_ff) > pcwe_pkg::CMP_W'(mag_ff));
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign push_cmd  = (ctl.uop == pcwe_pkg::UOP_PUSH_CMD) && !out_busy;
   assign push_pend = ((ctl.uop == pcwe_pkg::UOP_PUSH_PEND) ||
                       (ctl.uop == pcwe_pkg::UOP_PUSH_LAST)) && pend_ff && !out_busy;
   assign push      = push_cmd | push_pend;

   assign phase_in = (phase_ff == pcwe_pkg::PH_W'(pcwe_pkg::CHECK_DIVIDER - 1)) ?
                     '0 : phase_ff + pcwe_pkg::PH_W'(1);

   always_comb begin
      status.no_item   = !req_valid;
      status.is_tick   = item_ff.op;
      status.skip      = skip;
      status.phase_nz  = (phase_ff != '0);
      status.no_hit    = !hit;
      status.more_ch   = (scan_ch_ff != CW'(NCH - 1));
      status.out_busy  = out_busy;
      status.wait_pend = pend_ff && out_busy;
   end

   always_comb begin
      led = pcwe_pkg::led_encode(push_cmd ? duty_ff : pend_duty_ff);
      rsp_word_in.out_channel  = push_cmd ? item_ff.channel : 4'(pend_ch_ff);
      rsp_word_in.on_low       = 8'd0;
      rsp_word_in.on_high      = led.on_high;
      rsp_word_in.off_low      = led.off_low;
      rsp_word_in.off_high     = led.off_high;
      rsp_word_in.from_timeout = !push_cmd;
      rsp_word_in.last         = push_cmd || (ctl.uop == pcwe_pkg::UOP_PUSH_LAST);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ch_ff <= 4'd0;
         for (int i = 0; i < NCH; i++) begin
            timeout_table_ff[i]  <= pcwe_pkg::TIMEOUT_RESET;
            fallback_table_ff[i] <= 16'd0;
            min_table_ff[i]      <= 16'd0;
            max_table_ff[i]      <= pcwe_pkg::DUTY_MAX_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            pcwe_pkg::CSR_TABLE_CHANNEL: table_ch_ff <= csr_wdata[3:0];
            pcwe_pkg::CSR_TIMEOUT: begin
               if (tab_ok) timeout_table_ff[tab_idx] <= csr_wdata;
            end
            pcwe_pkg::CSR_FALLBACK: begin
               if (tab_ok) fallback_table_ff[tab_idx] <= csr_wdata[15:0];
            end
            pcwe_pkg::CSR_DUTY_MIN: begin
               if (tab_ok) min_table_ff[tab_idx] <= csr_wdata[15:0];
            end
            pcwe_pkg::CSR_DUTY_MAX: begin
               if (tab_ok) max_table_ff[tab_idx] <= csr_wdata[15:0];
            end
            default: ;
         endcase
      end
   end

   // command history, updated only by an accepted command
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            last_set_ff[i]    <= '0;
            last_change_ff[i] <= '0;
            last_cmd_ff[i]    <= 31'd0;
         end
      end else if (ctl.uop == pcwe_pkg::UOP_CMD_UPDATE && !skip) begin
         last_set_ff[cmd_idx] <= item_time;
         last_cmd_ff[cmd_idx] <= cmd_val[30:0];
         if (cmd_changed_ff) last_change_ff[cmd_idx] <= item_time;
      end
   end

   // item latch and command path
   always_ff @(posedge clock) begin
      if (ctl.uop == pcwe_pkg::UOP_FETCH && req_valid) item_ff <= req_word;
      if (ctl.uop == pcwe_pkg::UOP_CMD_READ) begin
         cmd_bad_ff     <= (int'(item_ff.channel) >= NCH) | cmd_val[31];
         cmd_changed_ff <= (cmd_val[30:0] != last_cmd_ff[cmd_idx]);
         ent_tmo_ff     <= timeout_table_ff[cmd_idx];
         ent_min_ff     <= min_table_ff[cmd_idx];
         ent_max_ff     <= max_table_ff[cmd_idx];
      end
      if (ctl.uop == pcwe_pkg::UOP_CMD_UPDATE) duty_ff <= clamp;
   end

   // scan unit: one channel per pass, difference and magnitude registered
   always_ff @(posedge clock) begin
      if (ctl.uop == pcwe_pkg::UOP_SCAN_READ) begin
         to_nz_ff <= (scan_tmo != 32'd0);
         mag_ff   <= scan_tmo[31] ? (33'd0 - {1'b1, scan_tmo}) : {1'b0, scan_tmo};
         diff_ff  <= item_time - (scan_tmo[31] ? last_change_ff[scan_ch_ff]
                                               : last_set_ff[scan_ch_ff]);
         fb_ff    <= fallback_table_ff[scan_ch_ff];
      end
      if (ctl.uop == pcwe_pkg::UOP_SET_PEND) begin
         pend_ch_ff   <= scan_ch_ff;
         pend_duty_ff <= fb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         scan_ch_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         if (ctl.uop == pcwe_pkg::UOP_TICK_START) begin
            phase_ff   <= phase_in;
            scan_ch_ff <= '0;
         end else if (ctl.uop == pcwe_pkg::UOP_NEXT_CH) begin
            scan_ch_ff <= scan_ch_ff + CW'(1);
         end
         if (ctl.uop == pcwe_pkg::UOP_SET_PEND) begin
            pend_ff <= 1'b1;
         end else if (push_pend || ctl.uop == pcwe_pkg::UOP_TICK_START) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_pend_drained: assert property (@(posedge clock) disable iff (reset)
      ctl.uop == pcwe_pkg::UOP_FETCH |-> !pend_ff)
      else $error("pending fallback word left behind at fetch");
   a_cmd_word: assert property (@(posedge clock) disable iff (reset)
      push_cmd |=> rsp_valid_ff && rsp_word_ff.last && !rsp_word_ff.from_timeout)
      else $error("command word not flagged as last and direct");
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl.uop == pcwe_pkg::UOP_SET_PEND |-> to_nz_ff)
      else $error("fallback queued for a channel without watchdog");
`endif

endmodule
`default_nettype wire

// File: rtl/pwm_channel_watchdog_encoder.sv
// Top level of the sixteen-channel PWM command gate with per-channel watchdog.
// Usage:
//   req_ channel carries one word per input: a channel command (op = 0) or a
//   time tick (op = 1). A word is taken when req_valid is high and req_stall
//   low; req_stall is low only while the sequencer sits at its fetch step.
//   rsp_ channel carries LED register writes. A command yields at most one
//   word (last set). Every tenth tick, counting the first, scans all
//   channels and yields one word per expired channel, last set on the final.
//   csr_ port writes table_channel and the per-channel table entry it selects.
// Steps: a command is fetched, its table entries read, the history updated
//   and the word pushed; a dropped command skips the push. A scanning tick
//   visits the sixteen channels in turn, set by the microprogram: one table
//   entry read and one compare per pass.
// Output: one registered word; while it waits under rsp_stall, a push step
//   with a word to send holds, takes no new input, and the waiting word stays.
// Reset (synchronous, active high): tables return to their defaults, the
//   command history and tick phase clear, the output register empties.
`timescale 1ns / 1ps
`default_nettype none
module pwm_channel_watchdog_encoder (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire pcwe_pkg::req_word_type  req_word,
   input  wire logic                    csr_we,
   input  wire logic [2:0]              csr_index,
   input  wire logic [31:0]             csr_wdata,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output pcwe_pkg::rsp_word_type       rsp_word
);

   pcwe_pkg::ctrl_word_type ctl;
   pcwe_pkg::status_type    status;

   // Sequencer steps the microprogram; branches read datapath status.
   pcwe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // Datapath executes one control word per cycle.
   pcwe_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .status    (status),
      .req_valid (req_valid),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // Take a new word only at the fetch step.
   assign req_stall = (ctl.uop != pcwe_pkg::UOP_FETCH);

endmodule
`default_nettype wire
